// ===== sv/arpct_pkg.sv =====
package arpct_pkg;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;

   localparam logic CMD_LEARN  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_UPDATED  = 3'd2,
      ST_INSERTED = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic             en;
      logic             ip_we;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } mem_wr_type;

   typedef struct packed {
      logic             load;
      status_type       status;
      logic [MAC_W-1:0] mac;
   } result_type;

endpackage

// ===== sv/arpct_mem.sv =====
module arpct_mem #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic                          rd_valid,
   output logic [arpct_pkg::IP_W-1:0]    rd_ip,
   output logic [arpct_pkg::MAC_W-1:0]   rd_mac,
   input  arpct_pkg::mem_wr_type         wr,
   input  logic [IDX_W-1:0]              wr_addr
);

   logic [arpct_pkg::IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
   logic [arpct_pkg::MAC_W-1:0] mac_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]    valid_ff;
   logic                        rd_valid_ff;
   logic [arpct_pkg::IP_W-1:0]  rd_ip_ff;
   logic [arpct_pkg::MAC_W-1:0] rd_mac_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mac_mem[wr_addr] <= wr.mac;
         if (wr.ip_we) begin
            ip_mem[wr_addr] <= wr.ip;
         end
      end
      if (rd_en) begin
         rd_ip_ff  <= ip_mem[rd_addr];
         rd_mac_ff <= mac_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en && wr.ip_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_ip    = rd_ip_ff;
   assign rd_mac   = rd_mac_ff;

   a_insert_into_empty: assert property (@(posedge clock) disable iff (reset)
      wr.en && wr.ip_we |-> !valid_ff[wr_addr])
      else $error("insert targets a slot that is already valid");

endmodule

// ===== sv/arpct_scan.sv =====
module arpct_scan #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4,
   parameter int CNT_W         = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [arpct_pkg::IP_W-1:0]    req_ip,
   input  logic [arpct_pkg::MAC_W-1:0]   req_mac,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic                          rd_valid,
   input  logic [arpct_pkg::IP_W-1:0]    rd_ip,
   input  logic [arpct_pkg::MAC_W-1:0]   rd_mac,
   output arpct_pkg::mem_wr_type         wr,
   output logic [IDX_W-1:0]              wr_addr,
   input  logic                          out_free,
   output arpct_pkg::result_type         res
);

   arpct_pkg::seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0]            issue_ff, issue_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic                        cmd_ff, cmd_in;
   logic [arpct_pkg::IP_W-1:0]  key_ff, key_in;
   logic [arpct_pkg::MAC_W-1:0] mac_ff, mac_in;
   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [arpct_pkg::MAC_W-1:0] hit_mac_ff, hit_mac_in;
   logic                        free_ff, free_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic                        match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpct_pkg::SEQ_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      mac_ff      <= mac_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

   assign match = pend_ff && rd_valid && (rd_ip == key_ff);

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      mac_in      = mac_ff;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      hit_mac_in  = hit_mac_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = issue_ff[IDX_W-1:0];
      wr          = '0;
      wr_addr     = hit_idx_ff;
      res.load    = 1'b0;
      res.status  = arpct_pkg::ST_MISS;
      res.mac     = '0;
      unique case (state_ff)
         arpct_pkg::SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               key_in   = req_ip;
               mac_in   = req_mac;
               issue_in = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               state_in = arpct_pkg::SEQ_SCAN;
            end
         end
         arpct_pkg::SEQ_SCAN: begin
            if (issue_ff < CNT_W'(TABLE_ENTRIES)) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end
            if (match && !found_ff) begin
               found_in   = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_mac_in = rd_mac;
            end
            if (pend_ff && !rd_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = pend_idx_ff;
            end
            if (pend_ff && pend_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = arpct_pkg::SEQ_DONE;
            end
         end
         arpct_pkg::SEQ_DONE: begin
            if (out_free) begin
               res.load = 1'b1;
               state_in = arpct_pkg::SEQ_IDLE;
               if (cmd_ff == arpct_pkg::CMD_LOOKUP) begin
                  if (found_ff) begin
                     res.status = arpct_pkg::ST_HIT;
                     res.mac    = hit_mac_ff;
                  end else begin
                     res.status = arpct_pkg::ST_MISS;
                  end
               end else if (found_ff) begin
                  res.status = arpct_pkg::ST_UPDATED;
                  wr.en      = 1'b1;
                  wr.mac     = mac_ff;
                  wr_addr    = hit_idx_ff;
               end else if (free_ff) begin
                  res.status = arpct_pkg::ST_INSERTED;
                  wr.en      = 1'b1;
                  wr.ip_we   = 1'b1;
                  wr.ip      = key_ff;
                  wr.mac     = mac_ff;
                  wr_addr    = free_idx_ff;
               end else begin
                  res.status = arpct_pkg::ST_FULL;
               end
            end
         end
         default: begin
            state_in = arpct_pkg::SEQ_IDLE;
         end
      endcase
   end

   a_write_at_end: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == arpct_pkg::SEQ_DONE && res.load)
      else $error("table written outside the end of a scan");

   a_scan_reads_only: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> state_ff == arpct_pkg::SEQ_SCAN && !wr.en)
      else $error("table read outside a scan");

endmodule

// ===== sv/arp_cache_table_core.sv =====
// ARP cache table: IPv4 address to MAC address bindings.
// Request channel (req_*): one transaction per command. req_tuser is the
// command (0 learn, 1 look up), req_tdata carries the IP key and the MAC
// to store. Response channel (rsp_*): exactly one transaction per request,
// rsp_tuser is the status (0 hit, 1 miss, 2 updated, 3 inserted, 4 dropped
// because the table is full), rsp_tdata the MAC found on a hit, else zero.
// Each command walks all TABLE_ENTRIES slots through one comparator, one
// slot read per cycle from the table memory, before the response is
// written to the output register. req_tready is high only while the
// sequencer is idle, so a new request is not accepted until the
// previous one has loaded its response.
// The response sits in an output register; the next request is accepted
// while it waits. If rsp_tready stays low, the following command finishes
// its scan and holds before writing the table until the register frees.
// Reset clears all valid bits at once; the table is usable once
// reset falls.
module arp_cache_table_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // ip_addr[31:0], mac_in[79:32]
   input  logic [0:0]   req_tuser,   // command[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // mac_out[47:0]
   output logic [2:0]   rsp_tuser    // status[2:0]
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic                        rd_valid;
   logic [arpct_pkg::IP_W-1:0]  rd_ip;
   logic [arpct_pkg::MAC_W-1:0] rd_mac;
   arpct_pkg::mem_wr_type       wr;
   logic [IDX_W-1:0]            wr_addr;
   arpct_pkg::result_type       res;
   logic                        out_free;
   logic                        rsp_valid_ff;
   arpct_pkg::status_type       rsp_status_ff;
   logic [arpct_pkg::MAC_W-1:0] rsp_mac_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   arpct_mem #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_valid(rd_valid),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac),
      .wr      (wr),
      .wr_addr (wr_addr)
   );

   arpct_scan #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_cmd  (req_tuser[0]),
      .req_ip   (req_tdata[31:0]),
      .req_mac  (req_tdata[79:32]),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_ip    (rd_ip),
      .rd_mac   (rd_mac),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .out_free (out_free),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         rsp_status_ff <= res.status;
         rsp_mac_ff    <= res.mac;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_mac_ff;

   a_mac_zero_unless_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != arpct_pkg::ST_HIT |-> rsp_mac_ff == '0)
      else $error("nonzero MAC on a response other than a lookup hit");

endmodule
